>>> src/quaternion_vector_rotation_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion vector rotation block
// Shared helpers that write clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_TOP_DEFINES_SVH

// Overlapping implication, sampled on clk_i, disabled during reset.
`define QVR_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("qvr assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define QVR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("qvr assertion failed");

`endif

>>> src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Types, widths and register codes of the quaternion vector rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_W   = 32;               // Q16.16 vector component
  localparam int Q_W     = 16;               // Q1.14 quaternion component
  localparam int P1_W    = VEC_W + Q_W;      // first product
  localparam int S1_W    = P1_W + 2;         // sum of three products plus rounding
  localparam int RND1_SH = 10;
  localparam int T_W     = S1_W - RND1_SH;   // intermediate quaternion, 20 fraction bits
  localparam int P2_W    = T_W + Q_W;        // second product
  localparam int S2_W    = P2_W + 2;         // sum of four products plus rounding
  localparam int RND2_SH = 18;
  localparam int R_W     = S2_W - RND2_SH;   // rotated component before saturation

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_REAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_I    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_J    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_K    = CFG_IDX_W'(3);

  localparam logic signed [Q_W-1:0] QUAT_REAL_RST = 16'sd16384;

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    saturated;
  } rot_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_real;
    logic signed [Q_W-1:0] quat_i;
    logic signed [Q_W-1:0] quat_j;
    logic signed [Q_W-1:0] quat_k;
  } quat_t;

  // p * conj(q), rounded to 20 fraction bits.
  typedef struct packed {
    logic signed [T_W-1:0] tw;
    logic signed [T_W-1:0] ti;
    logic signed [T_W-1:0] tj;
    logic signed [T_W-1:0] tk;
  } tquat_t;

endpackage

>>> src/qvr_conj_stage.sv
// ----------------------------------------------------------------------------
// qvr_conj_stage
// Two pipeline stages forming t = (0, x, y, z) * conj(q): products, then sums.
// ----------------------------------------------------------------------------
module qvr_conj_stage import qvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  vec_t   vec_i,
  input  quat_t  quat_i,
  output logic   valid_o,
  output tquat_t t_o
);

  logic signed [P1_W-1:0] prod_d [12];
  logic signed [P1_W-1:0] prod_q [12];
  logic                   prod_vld_q;
  logic signed [S1_W-1:0] sum_w, sum_i, sum_j, sum_k;
  tquat_t                 t_d, t_q;
  logic                   t_vld_q;
  logic signed [S1_W-1:0] rnd;

  assign rnd = S1_W'(1) <<< (RND1_SH - 1);

  always_comb begin
    prod_d[0]  = P1_W'(vec_i.vec_x) * P1_W'(quat_i.quat_i);
    prod_d[1]  = P1_W'(vec_i.vec_y) * P1_W'(quat_i.quat_j);
    prod_d[2]  = P1_W'(vec_i.vec_z) * P1_W'(quat_i.quat_k);
    prod_d[3]  = P1_W'(vec_i.vec_x) * P1_W'(quat_i.quat_real);
    prod_d[4]  = P1_W'(vec_i.vec_y) * P1_W'(quat_i.quat_k);
    prod_d[5]  = P1_W'(vec_i.vec_z) * P1_W'(quat_i.quat_j);
    prod_d[6]  = P1_W'(vec_i.vec_x) * P1_W'(quat_i.quat_k);
    prod_d[7]  = P1_W'(vec_i.vec_y) * P1_W'(quat_i.quat_real);
    prod_d[8]  = P1_W'(vec_i.vec_z) * P1_W'(quat_i.quat_i);
    prod_d[9]  = P1_W'(vec_i.vec_y) * P1_W'(quat_i.quat_i);
    prod_d[10] = P1_W'(vec_i.vec_z) * P1_W'(quat_i.quat_real);
    prod_d[11] = P1_W'(vec_i.vec_x) * P1_W'(quat_i.quat_j);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Taking the upper bits after adding half an LSB rounds half toward +inf.
  always_comb begin
    sum_w = S1_W'(prod_q[0]) + S1_W'(prod_q[1]) + S1_W'(prod_q[2]) + rnd;
    sum_i = S1_W'(prod_q[3]) - S1_W'(prod_q[4]) + S1_W'(prod_q[5]) + rnd;
    sum_j = S1_W'(prod_q[6]) + S1_W'(prod_q[7]) - S1_W'(prod_q[8]) + rnd;
    sum_k = S1_W'(prod_q[9]) + S1_W'(prod_q[10]) - S1_W'(prod_q[11]) + rnd;
    t_d.tw = sum_w[S1_W-1:RND1_SH];
    t_d.ti = sum_i[S1_W-1:RND1_SH];
    t_d.tj = sum_j[S1_W-1:RND1_SH];
    t_d.tk = sum_k[S1_W-1:RND1_SH];
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      t_vld_q    <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      t_vld_q    <= prod_vld_q;
    end
  end

  assign valid_o = t_vld_q;
  assign t_o     = t_q;

endmodule

>>> src/qvr_rot_stage.sv
// ----------------------------------------------------------------------------
// qvr_rot_stage
// Two pipeline stages forming the imaginary part of q * t, with saturation.
// ----------------------------------------------------------------------------
module qvr_rot_stage import qvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  tquat_t t_i,
  input  quat_t  quat_i,
  output logic   valid_o,
  output rot_t   rot_o
);

  logic signed [P2_W-1:0] prod_d [12];
  logic signed [P2_W-1:0] prod_q [12];
  logic                   prod_vld_q;
  logic signed [S2_W-1:0] sum_i, sum_j, sum_k;
  logic signed [R_W-1:0]  r_i, r_j, r_k;
  logic                   sat_i, sat_j, sat_k;
  rot_t                   rot_d, rot_q;
  logic                   rot_vld_q;
  logic signed [S2_W-1:0] rnd;

  assign rnd = S2_W'(1) <<< (RND2_SH - 1);

  function automatic logic signed [VEC_W-1:0] clip(input logic signed [R_W-1:0] v);
    logic [R_W-VEC_W:0] hi;
    hi = v[R_W-1:VEC_W-1];
    if ((&hi) || !(|hi)) begin
      clip = v[VEC_W-1:0];
    end else if (v[R_W-1]) begin
      clip = {1'b1, {(VEC_W-1){1'b0}}};
    end else begin
      clip = {1'b0, {(VEC_W-1){1'b1}}};
    end
  endfunction

  function automatic logic out_of_range(input logic signed [R_W-1:0] v);
    logic [R_W-VEC_W:0] hi;
    hi = v[R_W-1:VEC_W-1];
    out_of_range = !((&hi) || !(|hi));
  endfunction

  always_comb begin
    prod_d[0]  = P2_W'(quat_i.quat_real) * P2_W'(t_i.ti);
    prod_d[1]  = P2_W'(quat_i.quat_i)    * P2_W'(t_i.tw);
    prod_d[2]  = P2_W'(quat_i.quat_j)    * P2_W'(t_i.tk);
    prod_d[3]  = P2_W'(quat_i.quat_k)    * P2_W'(t_i.tj);
    prod_d[4]  = P2_W'(quat_i.quat_real) * P2_W'(t_i.tj);
    prod_d[5]  = P2_W'(quat_i.quat_i)    * P2_W'(t_i.tk);
    prod_d[6]  = P2_W'(quat_i.quat_j)    * P2_W'(t_i.tw);
    prod_d[7]  = P2_W'(quat_i.quat_k)    * P2_W'(t_i.ti);
    prod_d[8]  = P2_W'(quat_i.quat_real) * P2_W'(t_i.tk);
    prod_d[9]  = P2_W'(quat_i.quat_i)    * P2_W'(t_i.tj);
    prod_d[10] = P2_W'(quat_i.quat_j)    * P2_W'(t_i.ti);
    prod_d[11] = P2_W'(quat_i.quat_k)    * P2_W'(t_i.tw);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    sum_i = S2_W'(prod_q[0]) + S2_W'(prod_q[1]) + S2_W'(prod_q[2])
          - S2_W'(prod_q[3]) + rnd;
    sum_j = S2_W'(prod_q[4]) - S2_W'(prod_q[5]) + S2_W'(prod_q[6])
          + S2_W'(prod_q[7]) + rnd;
    sum_k = S2_W'(prod_q[8]) + S2_W'(prod_q[9]) - S2_W'(prod_q[10])
          + S2_W'(prod_q[11]) + rnd;
    r_i = sum_i[S2_W-1:RND2_SH];
    r_j = sum_j[S2_W-1:RND2_SH];
    r_k = sum_k[S2_W-1:RND2_SH];
    sat_i = out_of_range(r_i);
    sat_j = out_of_range(r_j);
    sat_k = out_of_range(r_k);
    rot_d.rot_x     = clip(r_i);
    rot_d.rot_y     = clip(r_j);
    rot_d.rot_z     = clip(r_k);
    rot_d.saturated = sat_i | sat_j | sat_k;
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      rot_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      rot_vld_q  <= prod_vld_q;
    end
  end

  assign valid_o = rot_vld_q;
  assign rot_o   = rot_q;

endmodule

>>> src/quaternion_vector_rotation_top.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_top
// Rotates a stream of Q16.16 vectors by a configured Q1.14 quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Load the quaternion through the write port (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i): index 0 is the real part, 1 to 3 the i, j and k parts.
//   Unknown indexes are ignored. Write only while no beat is in flight.
//   Present a vector on vec_i with start high; it is taken at that clock
//   edge. busy stays low, so a new vector may be given in every cycle.
//   The result beat appears on result_o with valid_o high for one cycle,
//   once it has passed the pipeline registers in order: conjugate
//   products, conjugate sums, rotation products, rotation sums, one for
//   each of the two multiplier rows and the two adder rows.
//   Throughput is one vector per cycle, set by the fully pipelined
//   multiplier rows. The result carries a saturated flag when any component
//   was clipped to the Q16.16 range.
//   Reset clears all valid bits, so no result beat follows it, and loads
//   the identity quaternion. The receiver cannot stall: every result beat
//   is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_top import qvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [Q_W-1:0]       cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  vec_t                 vec_i,
  output logic                 valid_o,
  output rot_t                 result_o
);

  quat_t  quat_q;
  tquat_t t_w;
  logic   t_vld;
  logic   accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.quat_real <= QUAT_REAL_RST;
      quat_q.quat_i    <= '0;
      quat_q.quat_j    <= '0;
      quat_q.quat_k    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUAT_REAL: quat_q.quat_real <= cfg_wdata_i;
        CFG_QUAT_I:    quat_q.quat_i    <= cfg_wdata_i;
        CFG_QUAT_J:    quat_q.quat_j    <= cfg_wdata_i;
        CFG_QUAT_K:    quat_q.quat_k    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  qvr_conj_stage u_conj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .vec_i   (vec_i),
    .quat_i  (quat_q),
    .valid_o (t_vld),
    .t_o     (t_w)
  );

  qvr_rot_stage u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_vld),
    .t_i     (t_w),
    .quat_i  (quat_q),
    .valid_o (valid_o),
    .rot_o   (result_o)
  );

endmodule

>>> src/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_assertions
// Port-level assertions on latency and saturation, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_top_defines.svh"

module qvr_assertions import qvr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [Q_W-1:0]       cfg_wdata_i,
  input logic                 start,
  input logic                 busy,
  input vec_t                 vec_i,
  input logic                 valid_o,
  input rot_t                 result_o
);

  localparam logic signed [VEC_W-1:0] VMAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VMIN = {1'b1, {(VEC_W-1){1'b0}}};

  // Every accepted beat yields exactly one result beat, and every result beat comes from an accepted beat.
  `QVR_ASSERT_IMPL(a_accept_to_result, start && !busy, ##4 valid_o)
  `QVR_ASSERT_IMPL(a_result_from_accept, valid_o, $past(start && !busy, 4))
  // The pipeline never refuses a beat.
  `QVR_ASSERT_NEXT(a_never_busy, 1'b1, !busy)
  // A clipped result has at least one component at a rail.
  `QVR_ASSERT_IMPL(a_sat_at_rail, valid_o && result_o.saturated,
    result_o.rot_x == VMAX || result_o.rot_x == VMIN || result_o.rot_y == VMAX ||
    result_o.rot_y == VMIN || result_o.rot_z == VMAX || result_o.rot_z == VMIN)

endmodule

bind quaternion_vector_rotation_top qvr_assertions u_qvr_assertions (.*);
